// File: design/cmdt_pkg.sv
`default_nettype none
// ============================================================================
// cmdt_pkg: shared definitions of the CAN masked-ID dispatch table
//
// Table geometry, field widths, operation and status codes, and the types
// that pass between the sequencer, the slot RAM and the rank table.
// ============================================================================
package cmdt_pkg;

    // Table geometry.
    localparam int ENTRIES_PER_BUS = 16;
    localparam int BUS_COUNT       = 2;
    localparam int TOTAL_SLOTS     = ENTRIES_PER_BUS * BUS_COUNT;
    localparam int IDX_W           = (ENTRIES_PER_BUS > 1) ? $clog2(ENTRIES_PER_BUS) : 1;
    localparam int SLOT_W          = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int RANK_W          = IDX_W;
    localparam bit BUS1_PRESENT    = (BUS_COUNT > 1);

    // Field widths.
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int ID_W      = 29;
    localparam int STD_ID_W  = 11;
    localparam int HANDLE_W  = 8;
    localparam int TARGET_W  = 8;
    localparam int PAYLOAD_W = 64;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_ADD        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEL_HANDLE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_ID     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHG_ID     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CHG_TARGET = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FRAME      = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd4;

    // What the shared compare unit tests an entry against.
    typedef enum logic [1:0] {
        KIND_HANDLE,
        KIND_EXACT,
        KIND_MASKED
    } match_kind_t;

    // One word of the slot RAM.
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [ID_W-1:0]     mask;
        logic [HANDLE_W-1:0] owner;
        logic [TARGET_W-1:0] handler;
    } slot_word_t;

    // Update request for the valid and age-rank flops.
    typedef enum logic [1:0] {
        RANK_NOP,
        RANK_ADD,
        RANK_REMOVE
    } rank_op_t;

    typedef struct packed {
        rank_op_t          op;
        logic              bus;
        logic [SLOT_W-1:0] slot;
    } rank_cmd_t;

    // Physical slot of entry idx in the bank of bus.
    function automatic logic [SLOT_W-1:0] slot_addr(input logic bus,
                                                    input logic [IDX_W-1:0] idx);
        logic [SLOT_W-1:0] base;
        base = bus ? SLOT_W'(ENTRIES_PER_BUS) : SLOT_W'(0);
        return SLOT_W'(idx) + base;
    endfunction

endpackage
`default_nettype wire

// File: design/cmdt_if.sv
`default_nettype none
// ============================================================================
// cmdt_if: request and response channels of the dispatch table
//
// Each channel carries valid, ready and one word of payload fields.
// ============================================================================
interface cmdt_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [cmdt_pkg::MODE_W-1:0]          mode;
    logic                                 bus_select;
    logic [cmdt_pkg::ID_W-1:0]            filter_id;
    logic [cmdt_pkg::ID_W-1:0]            filter_mask;
    logic [cmdt_pkg::HANDLE_W-1:0]        entry_handle;
    logic [cmdt_pkg::TARGET_W-1:0]        entry_target;
    logic                                 frame_is_extended;
    logic [cmdt_pkg::STD_ID_W-1:0]        frame_std_id;
    logic [cmdt_pkg::ID_W-1:0]            frame_ext_id;
    logic [cmdt_pkg::PAYLOAD_W-1:0]       frame_payload;

    modport source (
        output valid, mode, bus_select, filter_id, filter_mask, entry_handle,
               entry_target, frame_is_extended, frame_std_id, frame_ext_id,
               frame_payload,
        input  ready
    );
    modport sink (
        input  valid, mode, bus_select, filter_id, filter_mask, entry_handle,
               entry_target, frame_is_extended, frame_std_id, frame_ext_id,
               frame_payload,
        output ready
    );
endinterface

interface cmdt_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [cmdt_pkg::STATUS_W-1:0]        status;
    logic                                 bus_out;
    logic [cmdt_pkg::HANDLE_W-1:0]        hit_handle;
    logic [cmdt_pkg::TARGET_W-1:0]        hit_target;
    logic [cmdt_pkg::PAYLOAD_W-1:0]       payload_out;

    modport source (
        output valid, status, bus_out, hit_handle, hit_target, payload_out,
        input  ready
    );
    modport sink (
        input  valid, status, bus_out, hit_handle, hit_target, payload_out,
        output ready
    );
endinterface
`default_nettype wire

// File: design/cmdt_slot_ram.sv
`default_nettype none
// ============================================================================
// cmdt_slot_ram: entry storage of the dispatch table
//
// One write port and one registered read port over all slots of both banks.
// ============================================================================
module cmdt_slot_ram (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [cmdt_pkg::SLOT_W-1:0] waddr,
    input  wire cmdt_pkg::slot_word_t        wdata,
    input  wire logic [cmdt_pkg::SLOT_W-1:0] raddr,
    output cmdt_pkg::slot_word_t             rdata
);

    cmdt_pkg::slot_word_t mem [cmdt_pkg::TOTAL_SLOTS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/cmdt_match_unit.sv
`default_nettype none
// ============================================================================
// cmdt_match_unit: shared entry comparator
//
// Tests one stored entry against the search key: by owner handle, by exact
// filter id, or by the frame id masked with the entry's own mask.
// ============================================================================
module cmdt_match_unit (
    input  wire cmdt_pkg::match_kind_t       kind,
    input  wire logic [cmdt_pkg::ID_W-1:0]   key,
    input  wire cmdt_pkg::slot_word_t        entry,
    output logic                             hit
);

    logic [cmdt_pkg::ID_W-1:0] lhs;
    logic [cmdt_pkg::ID_W-1:0] rhs;

    // Pick the operands of the single 29-bit equality compare.
    always_comb
    begin
        case (kind)
            cmdt_pkg::KIND_HANDLE:
            begin
                lhs = {{(cmdt_pkg::ID_W - cmdt_pkg::HANDLE_W){1'b0}}, entry.owner};
                rhs = key;
            end
            cmdt_pkg::KIND_EXACT:
            begin
                lhs = entry.id;
                rhs = key;
            end
            cmdt_pkg::KIND_MASKED:
            begin
                lhs = entry.id;
                rhs = key & entry.mask;
            end
            default:
            begin
                lhs = entry.id;
                rhs = ~entry.id;
            end
        endcase
        hit = (lhs == rhs);
    end

endmodule
`default_nettype wire

// File: design/cmdt_rank_table.sv
`default_nettype none
// ============================================================================
// cmdt_rank_table: valid bits and age ranks of all slots
//
// Rank 0 is the newest entry of a bank. An add ages every valid entry of the
// bank by one; a remove closes the gap above the removed entry's rank.
// ============================================================================
module cmdt_rank_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cmdt_pkg::rank_cmd_t         cmd,
    input  wire logic [cmdt_pkg::SLOT_W-1:0] rd_slot,
    output logic                             rd_valid,
    output logic [cmdt_pkg::RANK_W-1:0]      rd_rank
);

    logic                          valid_reg [cmdt_pkg::TOTAL_SLOTS];
    logic [cmdt_pkg::RANK_W-1:0]   rank_reg  [cmdt_pkg::TOTAL_SLOTS];
    logic [cmdt_pkg::RANK_W-1:0]   rem_rank;

    // Lookup for the scan and for the rank of the slot being removed.
    assign rd_valid = valid_reg[rd_slot];
    assign rd_rank  = rank_reg[rd_slot];
    assign rem_rank = rank_reg[cmd.slot];

    // Per-slot update logic.
    for (genvar t = 0; t < cmdt_pkg::TOTAL_SLOTS; t++)
    begin : g_slot
        localparam int BANK = t / cmdt_pkg::ENTRIES_PER_BUS;
        localparam logic [cmdt_pkg::SLOT_W-1:0] SLOT_ID = cmdt_pkg::SLOT_W'(t);

        logic in_bank;
        assign in_bank = (BANK == 0) ? !cmd.bus : cmd.bus;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[t] <= 1'b0;
                rank_reg[t]  <= '0;
            end
            else
            begin
                case (cmd.op)
                    cmdt_pkg::RANK_ADD:
                    begin
                        if (cmd.slot == SLOT_ID)
                        begin
                            valid_reg[t] <= 1'b1;
                            rank_reg[t]  <= '0;
                        end
                        else if (in_bank && valid_reg[t])
                        begin
                            rank_reg[t] <= rank_reg[t] + 1'b1;
                        end
                    end
                    cmdt_pkg::RANK_REMOVE:
                    begin
                        if (cmd.slot == SLOT_ID)
                        begin
                            valid_reg[t] <= 1'b0;
                        end
                        else if (in_bank && valid_reg[t] && (rank_reg[t] > rem_rank))
                        begin
                            rank_reg[t] <= rank_reg[t] - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // An add must land in a free slot, and a remove must hit a live one.
    a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cmdt_pkg::RANK_ADD) |-> !valid_reg[cmd.slot])
        else $error("add targets a slot that is already valid");

    a_remove_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cmdt_pkg::RANK_REMOVE) |-> valid_reg[cmd.slot])
        else $error("remove targets a slot that is not valid");

    a_add_newest: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cmdt_pkg::RANK_ADD) |=>
        (valid_reg[$past(cmd.slot)] && (rank_reg[$past(cmd.slot)] == '0)))
        else $error("added slot is not valid with the newest rank");

    a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cmdt_pkg::RANK_REMOVE) |=> !valid_reg[$past(cmd.slot)])
        else $error("removed slot is still valid");

endmodule
`default_nettype wire

// File: design/can_masked_id_dispatch_table_core.sv
`default_nettype none
// ============================================================================
// can_masked_id_dispatch_table_core: masked CAN identifier dispatch table
//
// Per-bus routing table with add, delete, change and frame dispatch words.
// ============================================================================
// Each request word runs one operation on the bank named by bus_select and
// returns exactly one response word. A valid request scans the bank one entry
// per cycle through the single read port of the slot RAM and the shared
// comparator, and no new request is taken until it has finished; a request
// rejected as invalid argument skips the scan. Searches return the newest
// matching entry. The response sits in an output register, so a new request
// is taken while the previous response is still waiting; a finished operation
// waits only if that register is still full. The table is empty after reset
// with no clearing pass.
// ============================================================================
module can_masked_id_dispatch_table_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cmdt_req_if.sink    req,
    cmdt_rsp_if.source  rsp
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam logic [cmdt_pkg::IDX_W-1:0] LAST_IDX =
        cmdt_pkg::IDX_W'(cmdt_pkg::ENTRIES_PER_BUS - 1);

    state_t state_reg, state_next;

    // Captured request.
    logic [cmdt_pkg::MODE_W-1:0]     mode_reg;
    logic                            bus_reg;
    logic [cmdt_pkg::ID_W-1:0]       fid_reg;
    logic [cmdt_pkg::ID_W-1:0]       fmask_reg;
    logic [cmdt_pkg::HANDLE_W-1:0]   handle_reg;
    logic [cmdt_pkg::TARGET_W-1:0]   target_reg;
    logic [cmdt_pkg::ID_W-1:0]       key_reg;
    cmdt_pkg::match_kind_t           kind_reg;
    logic [cmdt_pkg::PAYLOAD_W-1:0]  payload_reg;
    logic                            invalid_reg;

    // Request decode.
    logic                            accept;
    logic                            in_bad;
    logic                            in_invalid;
    cmdt_pkg::match_kind_t           in_kind;
    logic [cmdt_pkg::ID_W-1:0]       in_key;

    // Scan state.
    logic [cmdt_pkg::IDX_W-1:0]      scan_idx_reg;
    logic                            cmp_vld_reg;
    logic [cmdt_pkg::IDX_W-1:0]      cmp_idx_reg;
    logic                            best_found_reg;
    logic [cmdt_pkg::IDX_W-1:0]      best_idx_reg;
    logic [cmdt_pkg::RANK_W-1:0]     best_rank_reg;
    cmdt_pkg::slot_word_t            best_word_reg;
    logic                            free_found_reg;
    logic [cmdt_pkg::IDX_W-1:0]      free_idx_reg;

    // Table access.
    logic                            ram_we;
    logic [cmdt_pkg::SLOT_W-1:0]     ram_waddr;
    cmdt_pkg::slot_word_t            ram_wdata;
    cmdt_pkg::slot_word_t            ram_rdata;
    cmdt_pkg::rank_cmd_t             rank_cmd;
    logic                            rd_valid;
    logic [cmdt_pkg::RANK_W-1:0]     rd_rank;
    logic                            match_hit;
    logic                            entry_hit;
    logic                            take_best;

    // Result.
    logic                            finish_go;
    logic [cmdt_pkg::STATUS_W-1:0]   res_status;
    logic [cmdt_pkg::HANDLE_W-1:0]   res_handle;
    logic [cmdt_pkg::TARGET_W-1:0]   res_target;
    logic [cmdt_pkg::PAYLOAD_W-1:0]  res_payload;
    logic                            out_valid_reg;
    logic [cmdt_pkg::STATUS_W-1:0]   out_status_reg;
    logic                            out_bus_reg;
    logic [cmdt_pkg::HANDLE_W-1:0]   out_handle_reg;
    logic [cmdt_pkg::TARGET_W-1:0]   out_target_reg;
    logic [cmdt_pkg::PAYLOAD_W-1:0]  out_payload_reg;

    // Handshake.
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    // Decode the request: search kind, search key and argument checks.
    always_comb
    begin
        in_kind = cmdt_pkg::KIND_HANDLE;
        in_key  = req.filter_id;
        in_bad  = 1'b0;
        case (req.mode)
            cmdt_pkg::MODE_ADD:
            begin
                in_kind = cmdt_pkg::KIND_EXACT;
                in_bad  = (req.entry_target == '0);
            end
            cmdt_pkg::MODE_DEL_HANDLE:
            begin
                in_key = {{(cmdt_pkg::ID_W - cmdt_pkg::HANDLE_W){1'b0}}, req.entry_handle};
                in_bad = (req.entry_handle == '0);
            end
            cmdt_pkg::MODE_DEL_ID:
            begin
                in_kind = cmdt_pkg::KIND_EXACT;
            end
            cmdt_pkg::MODE_CHG_ID:
            begin
                in_key = {{(cmdt_pkg::ID_W - cmdt_pkg::HANDLE_W){1'b0}}, req.entry_handle};
            end
            cmdt_pkg::MODE_CHG_TARGET:
            begin
                in_key = {{(cmdt_pkg::ID_W - cmdt_pkg::HANDLE_W){1'b0}}, req.entry_handle};
                in_bad = (req.entry_target == '0);
            end
            cmdt_pkg::MODE_FRAME:
            begin
                in_kind = cmdt_pkg::KIND_MASKED;
                in_key  = req.frame_is_extended ? req.frame_ext_id :
                          {{(cmdt_pkg::ID_W - cmdt_pkg::STD_ID_W){1'b0}}, req.frame_std_id};
            end
            default:
            begin
                in_bad = 1'b1;
            end
        endcase
        in_invalid = in_bad || (req.bus_select && !cmdt_pkg::BUS1_PRESENT);
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_invalid ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (accept)
            begin
                invalid_reg <= in_invalid;
            end
        end
    end

    // Capture the request word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= req.mode;
            bus_reg     <= req.bus_select;
            fid_reg     <= req.filter_id;
            fmask_reg   <= req.filter_mask;
            handle_reg  <= req.entry_handle;
            target_reg  <= req.entry_target;
            key_reg     <= in_key;
            kind_reg    <= in_kind;
            payload_reg <= req.frame_payload;
        end
    end

    // Slot storage, read one entry per scan cycle.
    cmdt_slot_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cmdt_pkg::slot_addr(bus_reg, scan_idx_reg)),
        .rdata (ram_rdata)
    );

    cmdt_rank_table u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (rank_cmd),
        .rd_slot  (cmdt_pkg::slot_addr(bus_reg, cmp_idx_reg)),
        .rd_valid (rd_valid),
        .rd_rank  (rd_rank)
    );

    cmdt_match_unit u_match (
        .kind  (kind_reg),
        .key   (key_reg),
        .entry (ram_rdata),
        .hit   (match_hit)
    );

    // Keep the newest hit and the first free slot seen so far.
    assign entry_hit = cmp_vld_reg && rd_valid && match_hit;
    assign take_best = entry_hit && (!best_found_reg || (rd_rank < best_rank_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (accept)
        begin
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (take_best)
            begin
                best_found_reg <= 1'b1;
            end
            if (cmp_vld_reg && !rd_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scan_idx_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (take_best)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_rank_reg <= rd_rank;
            best_word_reg <= ram_rdata;
        end
        if (cmp_vld_reg && !rd_valid && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // Result and table update at the end of the scan.
    always_comb
    begin
        res_status    = cmdt_pkg::STAT_INVALID;
        res_handle    = '0;
        res_target    = '0;
        res_payload   = '0;
        ram_we        = 1'b0;
        ram_waddr     = cmdt_pkg::slot_addr(bus_reg, best_idx_reg);
        ram_wdata     = best_word_reg;
        rank_cmd.op   = cmdt_pkg::RANK_NOP;
        rank_cmd.bus  = bus_reg;
        if (!invalid_reg)
        begin
            case (mode_reg)
                cmdt_pkg::MODE_ADD:
                begin
                    if (best_found_reg)
                    begin
                        res_status = cmdt_pkg::STAT_DUPLICATE;
                    end
                    else if (!free_found_reg)
                    begin
                        res_status = cmdt_pkg::STAT_FULL;
                    end
                    else
                    begin
                        res_status        = cmdt_pkg::STAT_OK;
                        ram_waddr         = cmdt_pkg::slot_addr(bus_reg, free_idx_reg);
                        ram_wdata.id      = fid_reg;
                        ram_wdata.mask    = fmask_reg;
                        ram_wdata.owner   = handle_reg;
                        ram_wdata.handler = target_reg;
                        ram_we            = finish_go;
                        if (finish_go)
                        begin
                            rank_cmd.op = cmdt_pkg::RANK_ADD;
                        end
                    end
                end
                cmdt_pkg::MODE_DEL_HANDLE, cmdt_pkg::MODE_DEL_ID:
                begin
                    if (best_found_reg)
                    begin
                        res_status = cmdt_pkg::STAT_OK;
                        if (finish_go)
                        begin
                            rank_cmd.op = cmdt_pkg::RANK_REMOVE;
                        end
                    end
                    else
                    begin
                        res_status = cmdt_pkg::STAT_NOT_FOUND;
                    end
                end
                cmdt_pkg::MODE_CHG_ID:
                begin
                    if (best_found_reg)
                    begin
                        res_status     = cmdt_pkg::STAT_OK;
                        ram_wdata.id   = fid_reg;
                        ram_wdata.mask = fmask_reg;
                        ram_we         = finish_go;
                    end
                    else
                    begin
                        res_status = cmdt_pkg::STAT_NOT_FOUND;
                    end
                end
                cmdt_pkg::MODE_CHG_TARGET:
                begin
                    if (best_found_reg)
                    begin
                        res_status        = cmdt_pkg::STAT_OK;
                        ram_wdata.handler = target_reg;
                        ram_we            = finish_go;
                    end
                    else
                    begin
                        res_status = cmdt_pkg::STAT_NOT_FOUND;
                    end
                end
                cmdt_pkg::MODE_FRAME:
                begin
                    if (best_found_reg)
                    begin
                        res_status  = cmdt_pkg::STAT_OK;
                        res_handle  = best_word_reg.owner;
                        res_target  = best_word_reg.handler;
                        res_payload = payload_reg;
                    end
                    else
                    begin
                        res_status = cmdt_pkg::STAT_NOT_FOUND;
                    end
                end
                default:
                begin
                    res_status = cmdt_pkg::STAT_INVALID;
                end
            endcase
        end
        rank_cmd.slot = ram_waddr;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            out_status_reg  <= res_status;
            out_bus_reg     <= bus_reg;
            out_handle_reg  <= res_handle;
            out_target_reg  <= res_target;
            out_payload_reg <= res_payload;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.bus_out     = out_bus_reg;
    assign rsp.hit_handle  = out_handle_reg;
    assign rsp.hit_target  = out_target_reg;
    assign rsp.payload_out = out_payload_reg;

endmodule
`default_nettype wire
